/* hw/rtl/ps2mpa_pkg.sv */
package ps2mpa_pkg;

  localparam int unsigned RING_DEPTH_DEF = 32;

  // Bit that must be set in the first byte of every packet
  localparam int unsigned SYNC_BIT = 3;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PKT_W  = 3 * BYTE_W;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Index of the next byte within a packet
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_LAST  = 2'd2;

  // Result flags, pkt_valid in bit 0
  typedef struct packed {
    logic packet_done;
    logic packet_dropped;
    logic byte_discarded;
    logic ring_empty;
    logic pkt_valid;
  } res_flags_t;

  typedef struct packed {
    res_flags_t       flags;
    logic [PKT_W-1:0] pkt;
  } res_t;

endpackage

/* hw/rtl/ps2mpa_ring.sv */
module ps2mpa_ring #(
  parameter int unsigned RING_DEPTH = ps2mpa_pkg::RING_DEPTH_DEF,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [ps2mpa_pkg::PKT_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [ps2mpa_pkg::PKT_W-1:0] rdata_o
);

  logic [ps2mpa_pkg::PKT_W-1:0] mem_q [RING_DEPTH];
  logic [ps2mpa_pkg::PKT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ps2mpa_ctrl.sv */
module ps2mpa_ctrl #(
  parameter int unsigned RING_DEPTH = ps2mpa_pkg::RING_DEPTH_DEF,
  localparam int unsigned AW = $clog2(RING_DEPTH),
  localparam int unsigned PW = $clog2(2 * RING_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [ps2mpa_pkg::BYTE_W-1:0] data_byte_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ps2mpa_pkg::res_flags_t        res_flags_o,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [ps2mpa_pkg::PKT_W-1:0]  wdata_o,
  output logic                          re_o,
  output logic [AW-1:0]                 raddr_o
);

  localparam logic [PW-1:0] PTR_LAST = PW'(2 * RING_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(RING_DEPTH);
  localparam logic [PW:0]   SPAN_X   = (PW + 1)'(2 * RING_DEPTH);

  logic [1:0]                   phase_q, phase_d;
  logic [ps2mpa_pkg::BYTE_W-1:0] part0_q, part1_q;
  logic [PW-1:0]                wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic                         valid_q, valid_d;
  ps2mpa_pkg::res_flags_t       flags_q, flags_d;
  logic                         accept;
  logic                         ring_empty, ring_full;
  logic [PW:0]                  fill;
  logic [PW:0]                  wr_x, rd_x;
  logic [PW:0]                  wr_slot_x, rd_slot_x;
  logic                         load0, load1;

  assign in_ready_o = !valid_q || res_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign wr_x = {1'b0, wr_ptr_q};
  assign rd_x = {1'b0, rd_ptr_q};

  // Pointers count modulo twice the depth
  assign fill       = (wr_x >= rd_x) ? (wr_x - rd_x) : (wr_x + SPAN_X - rd_x);
  assign ring_empty = (wr_ptr_q == rd_ptr_q);
  assign ring_full  = (fill >= DEPTH_X);

  assign wr_slot_x = (wr_x >= DEPTH_X) ? (wr_x - DEPTH_X) : wr_x;
  assign rd_slot_x = (rd_x >= DEPTH_X) ? (rd_x - DEPTH_X) : rd_x;
  assign waddr_o   = wr_slot_x[AW-1:0];
  assign raddr_o   = rd_slot_x[AW-1:0];
  assign wdata_o   = {data_byte_i, part1_q, part0_q};

  always_comb begin
    phase_d  = phase_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    flags_d  = '0;
    we_o     = 1'b0;
    re_o     = 1'b0;
    load0    = 1'b0;
    load1    = 1'b0;
    valid_d  = valid_q && !res_ready_i;
    if (accept) begin
      valid_d = 1'b1;
      if (op_i == ps2mpa_pkg::OP_READ) begin
        if (ring_empty) begin
          flags_d.ring_empty = 1'b1;
        end else begin
          flags_d.pkt_valid = 1'b1;
          re_o              = 1'b1;
          rd_ptr_d          = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
        end
      end else if (phase_q == ps2mpa_pkg::PHASE_FIRST
                   && !data_byte_i[ps2mpa_pkg::SYNC_BIT]) begin
        // Drop and stay at the first byte to resynchronise
        flags_d.byte_discarded = 1'b1;
      end else if (phase_q < ps2mpa_pkg::PHASE_LAST) begin
        load0   = !phase_q[0];
        load1   = phase_q[0];
        phase_d = phase_q + 2'd1;
      end else begin
        phase_d = ps2mpa_pkg::PHASE_FIRST;
        if (ring_full) begin
          flags_d.packet_dropped = 1'b1;
        end else begin
          flags_d.packet_done = 1'b1;
          we_o                = 1'b1;
          wr_ptr_d            = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ps2mpa_pkg::PHASE_FIRST;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags_d;
    end
    if (load0) begin
      part0_q <= data_byte_i;
    end
    if (load1) begin
      part1_q <= data_byte_i;
    end
  end

  assign res_valid_o = valid_q;
  assign res_flags_o = flags_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= DEPTH_X)
    else $error("ring fill level beyond depth");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !(op_i == ps2mpa_pkg::OP_FEED && phase_q < ps2mpa_pkg::PHASE_LAST
                && (phase_q != ps2mpa_pkg::PHASE_FIRST
                    || data_byte_i[ps2mpa_pkg::SYNC_BIT]))
    |=> $onehot(flags_q))
    else $error("result beat without exactly one outcome flag");

  a_ptr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(wr_ptr_q) && $stable(rd_ptr_q) && $stable(phase_q))
    else $error("ring state moved without an accepted beat");

  a_read_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_o |=> rd_ptr_q != $past(rd_ptr_q) && flags_q.pkt_valid)
    else $error("packet read without pointer advance");
`endif

endmodule

/* hw/rtl/ps2mpa_skid.sv */
module ps2mpa_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ps2mpa_pkg::res_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ps2mpa_pkg::res_t  out_data_o
);

  ps2mpa_pkg::res_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             take;

  assign in_ready_o = !skid_valid_q;
  assign take       = in_valid_i && !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_valid_q && out_ready_i) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  // Load a beat into the output register, or park it in the skid slot while the output is stalled
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (!out_valid_q || out_ready_i) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end else if (out_valid_q && out_ready_i && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/ps2_mouse_packet_assembler_fifo.sv */
// Channel   Direction  tdata (low bit up)                   tuser (low bit up)
// s_axis    in         data_byte[7:0]                       op
// m_axis    out        pkt_byte0, pkt_byte1, pkt_byte2      pkt_valid, ring_empty,
//                                                           byte_discarded,
//                                                           packet_dropped, packet_done
//
// One beat is taken per cycle unless the output buffer is full; results leave through it.
// Phase, pointer and ring-port updates finish in the cycle of acceptance; the
// ring read data register and the result flag register form one stage.
// A two-entry output buffer keeps s_axis taking beats while a result waits.
// Reset clears phase, pointers and valids; ring contents are not cleared.
module ps2_mouse_packet_assembler_fifo #(
  parameter int unsigned RING_DEPTH = ps2mpa_pkg::RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // data_byte
  input  logic [0:0]  s_axis_tuser_i,  // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // pkt_byte0, pkt_byte1, pkt_byte2
  output logic [4:0]  m_axis_tuser_o   // pkt_valid, ring_empty, byte_discarded,
                                       // packet_dropped, packet_done
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  logic                         we, re;
  logic [AW-1:0]                waddr, raddr;
  logic [ps2mpa_pkg::PKT_W-1:0] wdata, rdata;
  logic                         res_valid, res_ready;
  ps2mpa_pkg::res_flags_t       res_flags;
  ps2mpa_pkg::res_t             res, out;

  ps2mpa_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i[0]),
    .data_byte_i (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_flags_o (res_flags),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr)
  );

  ps2mpa_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Packet bytes read as zero unless this beat returned a packet
  assign res.flags = res_flags;
  assign res.pkt   = res_flags.pkt_valid ? rdata : '0;

  ps2mpa_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out)
  );

  assign m_axis_tdata_o = out.pkt;
  assign m_axis_tuser_o = out.flags;

endmodule

/* sim/ps2_mouse_packet_assembler_fifo_tb.sv */
`timescale 1ns / 100ps

module ps2_mouse_packet_assembler_fifo_tb;

  localparam int unsigned RING_DEPTH = ps2mpa_pkg::RING_DEPTH_DEF;
  localparam int unsigned PTR_W = $clog2(2 * RING_DEPTH);
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned IDLE_PCT = 15;
  localparam int unsigned TAIL_CYCLES = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;  // data_byte
  logic [0:0]  s_axis_tuser_i = '0;  // op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // pkt_byte0, pkt_byte1, pkt_byte2
  logic [4:0]  m_axis_tuser_o;       // pkt_valid, ring_empty, byte_discarded,
                                     // packet_dropped, packet_done

  // Shadow of the block's state
  logic [1:0]                   pkt_phase;
  logic [7:0]                   held_bytes [2];
  logic [ps2mpa_pkg::PKT_W-1:0] ring_copy [RING_DEPTH];
  logic [PTR_W-1:0]             wr_ptr;
  logic [PTR_W-1:0]             rd_ptr;

  ps2mpa_pkg::res_t due_results [$];
  int unsigned      err_cnt;
  int unsigned      stall_cycles;
  bit               no_idle;

  ps2_mouse_packet_assembler_fifo u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Work out the result of one accepted beat and queue it
  task automatic track_packet_ring(logic op, logic [7:0] b);
    ps2mpa_pkg::res_t r;
    r = '0;
    if (op == ps2mpa_pkg::OP_READ) begin
      if (wr_ptr == rd_ptr) begin
        r.flags.ring_empty = 1'b1;
      end else begin
        r.pkt = ring_copy[rd_ptr[PTR_W-2:0]];
        r.flags.pkt_valid = 1'b1;
        rd_ptr = rd_ptr + 1'b1;
      end
    end else if (pkt_phase == ps2mpa_pkg::PHASE_FIRST && !b[ps2mpa_pkg::SYNC_BIT]) begin
      r.flags.byte_discarded = 1'b1;
    end else if (pkt_phase < ps2mpa_pkg::PHASE_LAST) begin
      held_bytes[pkt_phase[0]] = b;
      pkt_phase = pkt_phase + 2'd1;
    end else begin
      pkt_phase = ps2mpa_pkg::PHASE_FIRST;
      if (PTR_W'(wr_ptr - rd_ptr) >= RING_DEPTH) begin
        r.flags.packet_dropped = 1'b1;
      end else begin
        ring_copy[wr_ptr[PTR_W-2:0]] = {b, held_bytes[1], held_bytes[0]};
        wr_ptr = wr_ptr + 1'b1;
        r.flags.packet_done = 1'b1;
      end
    end
    due_results.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(logic op, logic [7:0] b);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_packet_ring(op, b);
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    send_beat(ps2mpa_pkg::OP_FEED,
              8'($urandom_range(0, 255)) | (8'd1 << ps2mpa_pkg::SYNC_BIT));
    send_beat(ps2mpa_pkg::OP_FEED, 8'($urandom_range(0, 255)));
    send_beat(ps2mpa_pkg::OP_FEED, 8'($urandom_range(0, 255)));
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic test_directed();
    send_beat(ps2mpa_pkg::OP_READ, 8'hFF);   // read on an empty ring
    send_beat(ps2mpa_pkg::OP_FEED, 8'h00);   // sync bit clear at phase zero: drop
    send_beat(ps2mpa_pkg::OP_FEED, 8'hF7);
    send_beat(ps2mpa_pkg::OP_FEED, 8'h08);
    send_beat(ps2mpa_pkg::OP_FEED, 8'h00);
    send_beat(ps2mpa_pkg::OP_FEED, 8'hFF);
    send_beat(ps2mpa_pkg::OP_FEED, 8'hFF);
    send_beat(ps2mpa_pkg::OP_FEED, 8'hFF);
    send_beat(ps2mpa_pkg::OP_FEED, 8'h00);
    // sync bit only matters on the first byte
    send_beat(ps2mpa_pkg::OP_FEED, 8'h0F);
    send_beat(ps2mpa_pkg::OP_FEED, 8'h00);
    send_beat(ps2mpa_pkg::OP_FEED, 8'h80);
    send_beat(ps2mpa_pkg::OP_READ, 8'h00);
    send_beat(ps2mpa_pkg::OP_READ, 8'h55);
    send_beat(ps2mpa_pkg::OP_READ, 8'hAA);
    send_beat(ps2mpa_pkg::OP_READ, 8'h00);
  endtask

  // Fill the ring past full, then drain it past empty
  task automatic test_ring_overflow();
    while (pkt_phase != ps2mpa_pkg::PHASE_FIRST)
      send_beat(ps2mpa_pkg::OP_FEED, 8'($urandom_range(0, 255)));
    while (wr_ptr != rd_ptr) send_beat(ps2mpa_pkg::OP_READ, 8'($urandom_range(0, 255)));
    repeat (RING_DEPTH + 2) send_packet();
    repeat (RING_DEPTH + 3) send_beat(ps2mpa_pkg::OP_READ, 8'($urandom_range(0, 255)));
  endtask

  // Mostly whole packets, with reads at a varying rate and some stray bytes
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned read_pct;
    int unsigned pick;
    sent = 0;
    read_pct = 25;
    while (sent < n_items) begin
      if ((sent % 60) < 3) read_pct = $urandom_range(5, 60);
      pick = $urandom_range(0, 99);
      if (pick < read_pct) begin
        send_beat(ps2mpa_pkg::OP_READ, 8'($urandom_range(0, 255)));
        sent += 1;
      end else if (pick < read_pct + 12) begin
        send_beat(ps2mpa_pkg::OP_FEED, 8'($urandom_range(0, 255)));
        sent += 1;
      end else begin
        send_packet();
        sent += 3;
      end
    end
  endtask

  task automatic test_no_idle(int unsigned n_items);
    no_idle = 1'b1;
    test_random_traffic(n_items);
    no_idle = 1'b0;
  endtask

  initial begin
    pkt_phase = ps2mpa_pkg::PHASE_FIRST;
    held_bytes[0] = '0;
    held_bytes[1] = '0;
    wr_ptr = '0;
    rd_ptr = '0;
    err_cnt = 0;
    no_idle = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_ring_overflow();
    test_random_traffic(250);
    test_no_idle(100);

    s_axis_tvalid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    ps2mpa_pkg::res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h %h", $time,
                 m_axis_tuser_o, m_axis_tdata_o);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("pkt_byte0", want.pkt[7:0], m_axis_tdata_o[7:0]);
        check_field("pkt_byte1", want.pkt[15:8], m_axis_tdata_o[15:8]);
        check_field("pkt_byte2", want.pkt[23:16], m_axis_tdata_o[23:16]);
        check_field("pkt_valid", 8'(want.flags.pkt_valid), 8'(m_axis_tuser_o[0]));
        check_field("ring_empty", 8'(want.flags.ring_empty), 8'(m_axis_tuser_o[1]));
        check_field("byte_discarded", 8'(want.flags.byte_discarded),
                    8'(m_axis_tuser_o[2]));
        check_field("packet_dropped", 8'(want.flags.packet_dropped),
                    8'(m_axis_tuser_o[3]));
        check_field("packet_done", 8'(want.flags.packet_done), 8'(m_axis_tuser_o[4]));
      end
    end
  end

  // Count cycles in which neither side moves a beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o)
        || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
